@@ hw/rtl/ptc_pkg.sv @@
// Shared constants, types and widths for pressure/temperature compensation.
package ptc_pkg;

    localparam int unsigned RawW = 24;
    localparam int unsigned TempW = 16;
    localparam int unsigned PresW = 18;
    localparam int unsigned OssW = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_WORD_A = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_WORD_B = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WORD_C = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_OSS = 2'd3;

    localparam logic [OssW-1:0] OssReset = 2'd3;

    localparam logic signed [31:0] TempOffset = 32'sd4000;
    localparam logic [31:0] B4Bias = 32'd32768;
    localparam logic [31:0] B7Scale = 32'd50000;
    localparam logic signed [31:0] CorrSq = 32'sd3038;
    localparam logic signed [31:0] CorrLin = -32'sd7357;
    localparam logic signed [31:0] CorrAdd = 32'sd3791;
    localparam logic [PresW-1:0] PresMax = 18'h3FFFF;

    localparam int unsigned MulW = 49;
    localparam int unsigned DivW = 32;

    typedef struct packed {
        logic start;
        logic sgn;
    } ptc_ctl_t;

endpackage

@@ hw/rtl/pressure_temp_compensation.sv @@
// Top level: sequencer for barometric temperature and pressure compensation.
// Products run on the bit-serial multiplier and quotients on the bit-serial divider; a zero
// divisor skips the division and ends the beat with the error flag set.
// Throughput: one beat at a time; the next is taken in the cycle after the result is loaded.
// The result register holds a stalled result while the next beat is processed.
// Reset clears the sequencer, calibration words and stored term; oversampling resets to three.
module pressure_temp_compensation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptc_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [ptc_pkg::CfgDataW-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [ptc_pkg::RawW-1:0]         raw_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             kind,
    output logic signed [ptc_pkg::TempW-1:0] temperature_tenths,
    output logic [ptc_pkg::PresW-1:0]        pressure_pa,
    output logic                             div_error
);
    import ptc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_T_MUL, S_T_DIV, S_T_END,
        S_P_SQ, S_P_B2, S_P_AC2, S_P_B3, S_P_AC3, S_P_B1, S_P_B4, S_P_B7,
        S_P_DIV, S_P_CSQ, S_P_CMUL, S_P_CLIN, S_P_END, S_OUT
    } state_t;

    state_t state_reg;
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [OssW-1:0] oss_reg;
    logic signed [31:0] b5_reg;
    logic func_reg;
    logic [RawW-1:0] raw_reg;
    logic signed [63:0] t1_reg;
    logic signed [63:0] t2_reg;
    logic signed [63:0] sq_reg;
    logic [31:0] p_reg;
    logic wait_reg;

    logic signed [TempW-1:0] w_temp_reg;
    logic [PresW-1:0] w_pres_reg;
    logic w_err_reg;

    logic o_valid_reg;
    logic o_kind_reg;
    logic signed [TempW-1:0] o_temp_reg;
    logic [PresW-1:0] o_pres_reg;
    logic o_err_reg;

    logic m_start;
    logic signed [MulW-1:0] m_a;
    logic signed [MulW-1:0] m_b;
    logic m_busy;
    logic signed [2*MulW-1:0] m_prod;
    ptc_ctl_t d_ctl;
    logic [DivW-1:0] d_num;
    logic [DivW-1:0] d_den;
    logic d_busy;
    logic [DivW-1:0] d_quot;

    logic signed [63:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic signed [63:0] b6;
    logic signed [63:0] x1;
    logic signed [63:0] dsum;
    logic signed [63:0] tv;
    logic signed [63:0] b3;
    logic [31:0] x3u;
    logic [31:0] b4;
    logic [31:0] up;
    logic [31:0] b7;
    logic [31:0] b7s;
    logic signed [63:0] pc;
    logic busy_any;
    logic in_acc;
    logic out_free;

    ptc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (m_start),
        .a     (m_a),
        .b     (m_b),
        .busy  (m_busy),
        .prod  (m_prod)
    );

    ptc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (d_ctl),
        .num   (d_num),
        .den   (d_den),
        .busy  (d_busy),
        .quot  (d_quot)
    );

    assign ac1 = 64'(signed'(cal_a_reg[63:48]));
    assign ac2 = 64'(signed'(cal_a_reg[47:32]));
    assign ac3 = 64'(signed'(cal_a_reg[31:16]));
    assign ac4 = {48'd0, cal_a_reg[15:0]};
    assign ac5 = {48'd0, cal_b_reg[63:48]};
    assign ac6 = {48'd0, cal_b_reg[47:32]};
    assign b1 = 64'(signed'(cal_b_reg[31:16]));
    assign b2 = 64'(signed'(cal_b_reg[15:0]));
    assign mc = 64'(signed'(cal_c_reg[31:16]));
    assign md = 64'(signed'(cal_c_reg[15:0]));
    assign b6 = 64'(b5_reg) - 64'(TempOffset);
    assign x1 = t1_reg;
    assign dsum = t1_reg + md;
    assign tv = (64'(b5_reg) + 64'sd8) >>> 4;
    assign b3 = (((ac1 <<< 2) + t1_reg) <<< oss_reg) + 64'sd2 >>> 2;
    assign x3u = 32'(((t1_reg + (m_prod >>> 16) + 64'sd2) >>> 2)) + B4Bias;
    assign b4 = {15'd0, m_prod[31:15]};
    assign up = 32'(raw_reg >> (4'd8 - {2'b00, oss_reg}));
    assign b7 = 32'(m_prod);
    assign b7s = b7[31] ? b7 : (b7 << 1);
    assign pc = 64'(signed'({1'b0, p_reg}))
        + 64'((t2_reg + (m_prod >>> 16) + 64'(CorrAdd)) >>> 4);
    assign busy_any = m_busy | d_busy;
    assign out_free = !o_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        m_start = 1'b0;
        m_a = '0;
        m_b = '0;
        d_ctl = '0;
        d_num = '0;
        d_den = '0;
        if (!wait_reg)
        begin
            unique case (state_reg)
                S_T_MUL:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(signed'({48'd0, raw_reg[15:0]}) - ac6);
                    m_b = MulW'(ac5);
                end
                S_T_DIV:
                begin
                    d_ctl.start = (dsum != 0);
                    d_ctl.sgn = 1'b1;
                    d_num = 32'(mc <<< 11);
                    d_den = 32'(dsum);
                end
                S_P_SQ:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(b6);
                    m_b = MulW'(b6);
                end
                S_P_B2:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(b2);
                    m_b = MulW'(sq_reg);
                end
                S_P_AC2:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(ac2);
                    m_b = MulW'(b6);
                end
                S_P_AC3:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(ac3);
                    m_b = MulW'(b6);
                end
                S_P_B1:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(b1);
                    m_b = MulW'(sq_reg);
                end
                S_P_B4:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(ac4);
                    m_b = MulW'(t1_reg[31:0]);
                end
                S_P_B7:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(signed'(up - t1_reg[31:0]));
                    m_b = MulW'(B7Scale >> oss_reg);
                end
                S_P_DIV:
                begin
                    d_ctl.start = (t2_reg[31:0] != '0);
                    d_ctl.sgn = 1'b0;
                    d_num = 32'(t1_reg);
                    d_den = t2_reg[31:0];
                end
                S_P_CSQ:
                begin
                    m_start = 1'b1;
                    m_a = MulW'({8'd0, p_reg[31:8]});
                    m_b = MulW'({8'd0, p_reg[31:8]});
                end
                S_P_CMUL:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(sq_reg);
                    m_b = MulW'(CorrSq);
                end
                S_P_CLIN:
                begin
                    m_start = 1'b1;
                    m_a = MulW'(CorrLin);
                    m_b = MulW'(signed'({1'b0, p_reg}));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg <= 1'b0;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg <= OssReset;
            b5_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (o_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                o_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WORD_A: cal_a_reg <= cfg_data;
                    CFG_WORD_B: cal_b_reg <= cfg_data;
                    CFG_WORD_C: cal_c_reg <= cfg_data[31:0];
                    CFG_OSS:    oss_reg <= cfg_data[OssW-1:0];
                    default:    cal_a_reg <= cal_a_reg;
                endcase
            end
            if (!wait_reg && (m_start || d_ctl.start))
            begin
                wait_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        func_reg <= func;
                        raw_reg <= raw_value;
                        w_temp_reg <= '0;
                        w_pres_reg <= '0;
                        w_err_reg <= 1'b0;
                        state_reg <= func ? S_P_SQ : S_T_MUL;
                    end
                end
                S_T_MUL:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t1_reg <= 64'(m_prod >>> 15);
                        state_reg <= S_T_DIV;
                    end
                end
                S_T_DIV:
                begin
                    if (!wait_reg && dsum == 0)
                    begin
                        w_err_reg <= 1'b1;
                        wait_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        b5_reg <= 32'(x1 + 64'(signed'(d_quot)));
                        state_reg <= S_T_END;
                    end
                end
                S_T_END:
                begin
                    if (tv > 64'sd32767)
                    begin
                        w_temp_reg <= 16'sh7FFF;
                    end
                    else if (tv < -64'sd32768)
                    begin
                        w_temp_reg <= 16'sh8000;
                    end
                    else
                    begin
                        w_temp_reg <= 16'(tv);
                    end
                    state_reg <= S_OUT;
                end
                S_P_SQ:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        sq_reg <= 64'(m_prod >>> 12);
                        state_reg <= S_P_B2;
                    end
                end
                S_P_B2:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t1_reg <= 64'(m_prod >>> 11);
                        state_reg <= S_P_AC2;
                    end
                end
                S_P_AC2:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t1_reg <= t1_reg + 64'(m_prod >>> 11);
                        state_reg <= S_P_B3;
                    end
                end
                S_P_B3:
                begin
                    t1_reg <= b3;
                    t2_reg <= b3;
                    wait_reg <= 1'b0;
                    state_reg <= S_P_AC3;
                end
                S_P_AC3:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t1_reg <= 64'(m_prod >>> 13);
                        state_reg <= S_P_B1;
                    end
                end
                S_P_B1:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        // hold combined X3 plus bias as the B4 multiplier operand
                        t1_reg <= 64'(x3u);
                        state_reg <= S_P_B4;
                    end
                end
                S_P_B4:
                begin
                    if (!wait_reg)
                    begin
                        t1_reg <= t2_reg;
                    end
                    else if (!busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t2_reg <= 64'(b4);
                        state_reg <= S_P_B7;
                    end
                end
                S_P_B7:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t1_reg <= 64'(b7s);
                        p_reg <= b7;
                        state_reg <= S_P_DIV;
                    end
                end
                S_P_DIV:
                begin
                    if (!wait_reg && t2_reg[31:0] == '0)
                    begin
                        w_err_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        p_reg <= p_reg[31] ? (d_quot << 1) : d_quot;
                        state_reg <= S_P_CSQ;
                    end
                end
                S_P_CSQ:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        sq_reg <= 64'(m_prod);
                        state_reg <= S_P_CMUL;
                    end
                end
                S_P_CMUL:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        t2_reg <= 64'(m_prod >>> 16);
                        state_reg <= S_P_CLIN;
                    end
                end
                S_P_CLIN:
                begin
                    if (wait_reg && !busy_any)
                    begin
                        wait_reg <= 1'b0;
                        state_reg <= S_P_END;
                    end
                end
                S_P_END:
                begin
                    if (pc < 0)
                    begin
                        w_pres_reg <= '0;
                    end
                    else if (pc > 64'(PresMax))
                    begin
                        w_pres_reg <= PresMax;
                    end
                    else
                    begin
                        w_pres_reg <= PresW'(pc);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        o_valid_reg <= 1'b1;
                        o_kind_reg <= func_reg;
                        o_temp_reg <= w_temp_reg;
                        o_pres_reg <= w_pres_reg;
                        o_err_reg <= w_err_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = o_valid_reg;
    assign kind = o_kind_reg;
    assign temperature_tenths = o_temp_reg;
    assign pressure_pa = o_pres_reg;
    assign div_error = o_err_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("beat taken while busy");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result without sequencer");
    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_busy && d_busy))
        else $error("multiplier and divider both busy");
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> (pressure_pa == '0 && temperature_tenths == '0))
        else $error("error result not zero");
`endif

endmodule

@@ hw/rtl/ptc_mul.sv @@
// Bit-serial signed multiplier, one multiplier bit per cycle.
module ptc_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [ptc_pkg::MulW-1:0]  a,
    input  logic signed [ptc_pkg::MulW-1:0]  b,
    output logic                             busy,
    output logic signed [2*ptc_pkg::MulW-1:0] prod
);
    import ptc_pkg::*;

    localparam int unsigned CntW = $clog2(MulW + 1);

    logic [CntW-1:0]           cnt_reg;
    logic [CntW-1:0]           cnt_next;
    logic signed [2*MulW-1:0]  acc_reg;
    logic signed [2*MulW-1:0]  acc_next;
    logic signed [2*MulW-1:0]  mcand_reg;
    logic signed [2*MulW-1:0]  mcand_next;
    logic [MulW-1:0]           mplier_reg;
    logic [MulW-1:0]           mplier_next;
    logic signed [2*MulW-1:0]  addend;

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        addend = '0;
        if (start)
        begin
            cnt_next = CntW'(MulW);
            acc_next = '0;
            mcand_next = (2*MulW)'(a);
            mplier_next = b;
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                addend = mcand_reg;
            end
            // top bit of the multiplier carries negative weight
            if (cnt_reg == CntW'(1))
            begin
                acc_next = acc_reg - addend;
            end
            else
            begin
                acc_next = acc_reg + addend;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

@@ hw/rtl/ptc_div.sv @@
// Bit-serial restoring divider for unsigned or signed-truncating division.
module ptc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptc_pkg::ptc_ctl_t           ctl,
    input  logic [ptc_pkg::DivW-1:0]    num,
    input  logic [ptc_pkg::DivW-1:0]    den,
    output logic                        busy,
    output logic [ptc_pkg::DivW-1:0]    quot
);
    import ptc_pkg::*;

    localparam int unsigned CntW = $clog2(DivW + 1);

    logic [CntW-1:0]  cnt_reg;
    logic [CntW-1:0]  cnt_next;
    logic [DivW-1:0]  q_reg;
    logic [DivW-1:0]  q_next;
    logic [DivW:0]    r_reg;
    logic [DivW:0]    r_next;
    logic [DivW-1:0]  d_reg;
    logic [DivW-1:0]  d_next;
    logic             neg_reg;
    logic             neg_next;
    logic [DivW:0]    trial;
    logic [DivW-1:0]  an;
    logic [DivW-1:0]  ad;

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        an = num;
        ad = den;
        trial = '0;
        if (ctl.sgn)
        begin
            an = num[DivW-1] ? (~num + DivW'(1)) : num;
            ad = den[DivW-1] ? (~den + DivW'(1)) : den;
        end
        if (ctl.start)
        begin
            cnt_next = CntW'(DivW);
            q_next = an;
            r_next = '0;
            d_next = ad;
            neg_next = ctl.sgn & (num[DivW-1] ^ den[DivW-1]);
        end
        else if (cnt_reg != '0)
        begin
            trial = {r_reg[DivW-1:0], q_reg[DivW-1]} - {1'b0, d_reg};
            if (!trial[DivW])
            begin
                r_next = trial;
                q_next = {q_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DivW-1:0], q_reg[DivW-1]};
                q_next = {q_reg[DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = neg_reg ? (~q_reg + DivW'(1)) : q_reg;

endmodule
